// File: rtl/sfp_pkg.sv
// Shared types, constants and the CRC16 byte update for the frame parser.
// No dependencies; used by every module of the block.

package sfp_pkg;

  // Frame format
  localparam logic [7:0]  SYNC_FIRST  = 8'h55;
  localparam logic [7:0]  SYNC_SECOND = 8'hAA;
  localparam logic [7:0]  MAX_PAYLOAD = 8'd128;

  // CRC16-MODBUS, reflected
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Result kinds
  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Summary status codes
  localparam logic [2:0] ST_ACKED  = 3'd0;
  localparam logic [2:0] ST_PASSED = 3'd1;
  localparam logic [2:0] ST_HEADER = 3'd2;
  localparam logic [2:0] ST_CRC    = 3'd3;
  localparam logic [2:0] ST_LONG   = 3'd4;
  localparam logic [2:0] ST_TRUNC  = 3'd5;

  // Reply codes
  localparam logic [1:0] RP_NONE = 2'd0;
  localparam logic [1:0] RP_ACK  = 2'd1;
  localparam logic [1:0] RP_NACK = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IV   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIG  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE = 2'd2;

  // Result queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [7:0] iv_code;
    logic [7:0] sig_code;
    logic [7:0] size_code;
  } cmd_codes_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [6:0]  byte_index;
    logic [2:0]  status;
    logic [7:0]  command;
    logic [7:0]  payload_length;
    logic [15:0] frame_size;
    logic [1:0]  reply;
    logic        last;
  } res_t;

  // Results of one parser step: up to two items, first in r0
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } step_out_t;

  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: rtl/sync_length_crc16_frame_parser_top.sv
// Top level of the length-prefixed frame parser with CRC16-MODBUS check.
// Depends on sfp_pkg, sfp_parser_step and sfp_result_fifo.
//
// Usage:
//  - Input channel (in_valid/in_ready): one received byte per item, with
//    in_block_end high on the last byte of a UART block. A block holds at
//    most one frame: 0x55 0xAA, length, command, payload, CRC low, CRC high.
//  - Output channel (out_valid/out_ready): payload bytes pass through as
//    kind 0 items; a kind 1 summary closes each frame or failed attempt with
//    status, command, length, frame size and the reply to send. One input
//    byte gives zero, one or two items; out_last marks the final one.
//  - Configuration: cfg_we writes cfg_wdata into the command code selected
//    by cfg_index (0 IV, 1 signature, 2 size); other indexes are dropped.
//    Write only while the parser is idle.
// Flow: an accepted item is held in the input register, then parsed by the
// parser step, which writes its results into the result queue. One
// byte per cycle is sustained; the parser step waits only when the result
// queue (four items) has fewer than two free places.
// Reset (rst_n low, synchronous) restores the code registers to 1, 2, 3,
// empties the queue and returns the parser to waiting for the first sync
// byte. A stalled receiver fills the queue, then the input register, and
// then in_ready drops; nothing is lost.

module sync_length_crc16_frame_parser_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // input items
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_rx_byte,
  input  logic                            in_block_end,
  // result items
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_kind,
  output logic [7:0]                      out_data_byte,
  output logic [6:0]                      out_byte_index,
  output logic [2:0]                      out_status,
  output logic [7:0]                      out_command,
  output logic [7:0]                      out_payload_length,
  output logic [15:0]                     out_frame_size,
  output logic [1:0]                      out_reply,
  output logic                            out_last,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [sfp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                      cfg_wdata
);

  // Command code registers
  logic [7:0] iv_code_r, sig_code_r, size_code_r;
  sfp_pkg::cmd_codes_t codes;

  // Input register stage
  logic       s1_vld_r, s1_vld_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_end_r;
  logic       in_fire, step_fire;

  sfp_pkg::step_out_t step_raw, step_push;
  sfp_pkg::res_t      out_item;
  logic               room2;
  logic [sfp_pkg::FIFO_CW-1:0] fifo_fill;

  assign codes.iv_code   = iv_code_r;
  assign codes.sig_code  = sig_code_r;
  assign codes.size_code = size_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_code_r   <= 8'd1;
      sig_code_r  <= 8'd2;
      size_code_r <= 8'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfp_pkg::CFG_IV:   iv_code_r   <= cfg_wdata;
        sfp_pkg::CFG_SIG:  sig_code_r  <= cfg_wdata;
        sfp_pkg::CFG_SIZE: size_code_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // The step consumes the held byte whenever the queue can take two items;
  // the input register refills in the same cycle.
  assign step_fire = s1_vld_r && room2;
  assign in_ready  = !s1_vld_r || step_fire;
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_fire) begin
      s1_vld_nxt = 1'b1;
    end else if (step_fire) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_rx_byte;
      s1_end_r  <= in_block_end;
    end
  end

  sfp_parser_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (step_fire),
    .rx_byte   (s1_byte_r),
    .block_end (s1_end_r),
    .codes     (codes),
    .step_out  (step_raw)
  );

  // Push only on a real step
  always_comb begin
    step_push = step_raw;
    if (!step_fire) begin
      step_push.n = 2'd0;
    end
  end

  sfp_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step_push),
    .room2     (room2),
    .fill      (fifo_fill),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  assign out_kind           = out_item.kind;
  assign out_data_byte      = out_item.data_byte;
  assign out_byte_index     = out_item.byte_index;
  assign out_status         = out_item.status;
  assign out_command        = out_item.command;
  assign out_payload_length = out_item.payload_length;
  assign out_frame_size     = out_item.frame_size;
  assign out_reply          = out_item.reply;
  assign out_last           = out_item.last;

  // Queue never holds more than its depth
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_fill <= sfp_pkg::FIFO_CW'(sfp_pkg::FIFO_DEPTH))
    else $error("result queue overfilled");

  // A two-item step is always a payload byte followed by a truncation summary
  a_two_items: assert property (@(posedge clk) disable iff (!rst_n)
    (step_fire && step_raw.n == 2'd2) |->
      (step_raw.r0.kind == sfp_pkg::KIND_DATA && !step_raw.r0.last &&
       step_raw.r1.status == sfp_pkg::ST_TRUNC && step_raw.r1.last))
    else $error("bad two-item step");

  // Nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result offered right after reset");

endmodule

// File: rtl/sfp_parser_step.sv
// Frame parser state and the per-byte step logic: phase, CRC, header fields.
// Depends on sfp_pkg.

module sfp_parser_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [7:0]          rx_byte,
  input  logic                block_end,
  input  sfp_pkg::cmd_codes_t codes,
  output sfp_pkg::step_out_t  step_out
);

  localparam logic [2:0] PH_SYNC1 = 3'd0;
  localparam logic [2:0] PH_SYNC2 = 3'd1;
  localparam logic [2:0] PH_LEN   = 3'd2;
  localparam logic [2:0] PH_CMD   = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_CRCLO = 3'd5;
  localparam logic [2:0] PH_CRCHI = 3'd6;
  localparam logic [2:0] PH_SKIP  = 3'd7;

  logic [2:0]  phase_r, phase_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [15:0] size_r, size_nxt;
  logic [7:0]  crclo_r, crclo_nxt;

  logic        data_en, sum_en, trunc_en, done;
  logic [2:0]  sum_st;
  logic [1:0]  sum_rp;
  logic [15:0] rx_crc;
  logic        cmd_known;
  sfp_pkg::res_t data_res, sum_res, trunc_res;

  assign rx_crc    = {rx_byte, crclo_r};
  assign cmd_known = (cmd_r == codes.iv_code) || (cmd_r == codes.sig_code) ||
                     (cmd_r == codes.size_code);

  always_comb begin
    phase_nxt = phase_r;
    crc_nxt   = crc_r;
    len_nxt   = len_r;
    cmd_nxt   = cmd_r;
    cnt_nxt   = cnt_r;
    size_nxt  = size_r;
    crclo_nxt = crclo_r;
    data_en   = 1'b0;
    sum_en    = 1'b0;
    done      = 1'b0;
    sum_st    = sfp_pkg::ST_HEADER;
    sum_rp    = sfp_pkg::RP_NONE;

    unique case (phase_r)
      PH_SYNC1: begin
        crc_nxt   = sfp_pkg::CRC_INIT;
        len_nxt   = 8'h00;
        cmd_nxt   = 8'h00;
        cnt_nxt   = 8'h00;
        size_nxt  = 16'h0000;
        crclo_nxt = 8'h00;
        if (rx_byte != sfp_pkg::SYNC_FIRST) begin
          sum_en = 1'b1;
          done   = 1'b1;
        end else begin
          phase_nxt = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        if (rx_byte != sfp_pkg::SYNC_SECOND) begin
          sum_en = 1'b1;
          done   = 1'b1;
        end else begin
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        len_nxt = rx_byte;
        crc_nxt = sfp_pkg::crc16_feed(crc_r, rx_byte);
        if (rx_byte > sfp_pkg::MAX_PAYLOAD) begin
          sum_en = 1'b1;
          sum_st = sfp_pkg::ST_LONG;
          done   = 1'b1;
        end else begin
          phase_nxt = PH_CMD;
        end
      end
      PH_CMD: begin
        cmd_nxt   = rx_byte;
        crc_nxt   = sfp_pkg::crc16_feed(crc_r, rx_byte);
        phase_nxt = (len_r == 8'h00) ? PH_CRCLO : PH_DATA;
      end
      PH_DATA: begin
        crc_nxt = sfp_pkg::crc16_feed(crc_r, rx_byte);
        data_en = 1'b1;
        if (cnt_r == 8'd0) begin
          size_nxt = {8'h00, rx_byte};
        end else if (cnt_r == 8'd1) begin
          size_nxt = size_r | {rx_byte, 8'h00};
        end
        cnt_nxt = cnt_r + 8'd1;
        if (cnt_nxt >= len_r) begin
          phase_nxt = PH_CRCLO;
        end
      end
      PH_CRCLO: begin
        crclo_nxt = rx_byte;
        phase_nxt = PH_CRCHI;
      end
      PH_CRCHI: begin
        sum_en = 1'b1;
        done   = 1'b1;
        if (rx_crc != crc_r) begin
          sum_st = sfp_pkg::ST_CRC;
          sum_rp = sfp_pkg::RP_NACK;
        end else if (cmd_known) begin
          sum_st = sfp_pkg::ST_ACKED;
          sum_rp = sfp_pkg::RP_ACK;
        end else begin
          sum_st = sfp_pkg::ST_PASSED;
        end
      end
      PH_SKIP: begin
      end
      default: begin
      end
    endcase

    // End of block: truncated unless the frame already finished or failed
    trunc_en = block_end && !done && (phase_r != PH_SKIP);
    if (block_end) begin
      phase_nxt = PH_SYNC1;
    end else if (done) begin
      phase_nxt = PH_SKIP;
    end
  end

  // Result items; summaries report header fields after this byte's update
  always_comb begin
    data_res            = '0;
    data_res.kind       = sfp_pkg::KIND_DATA;
    data_res.data_byte  = rx_byte;
    data_res.byte_index = cnt_r[6:0];

    sum_res                = '0;
    sum_res.kind           = sfp_pkg::KIND_SUMMARY;
    sum_res.status         = sum_st;
    sum_res.command        = cmd_nxt;
    sum_res.payload_length = len_nxt;
    sum_res.frame_size     = size_nxt;
    sum_res.reply          = sum_rp;

    trunc_res        = sum_res;
    trunc_res.status = sfp_pkg::ST_TRUNC;
    trunc_res.reply  = sfp_pkg::RP_NONE;
    trunc_res.last   = 1'b1;

    step_out.n = {1'b0, data_en | sum_en | trunc_en} + {1'b0, data_en & trunc_en};
    if (data_en) begin
      step_out.r0 = data_res;
    end else if (sum_en) begin
      step_out.r0 = sum_res;
    end else begin
      step_out.r0 = trunc_res;
    end
    step_out.r0.last = (step_out.n == 2'd1);
    step_out.r1      = trunc_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SYNC1;
      crc_r   <= sfp_pkg::CRC_INIT;
      len_r   <= 8'h00;
      cmd_r   <= 8'h00;
      cnt_r   <= 8'h00;
      size_r  <= 16'h0000;
      crclo_r <= 8'h00;
    end else if (fire) begin
      phase_r <= phase_nxt;
      crc_r   <= crc_nxt;
      len_r   <= len_nxt;
      cmd_r   <= cmd_nxt;
      cnt_r   <= cnt_nxt;
      size_r  <= size_nxt;
      crclo_r <= crclo_nxt;
    end
  end

endmodule

// File: rtl/sfp_result_fifo.sv
// Small result queue: takes up to two items per cycle, gives one per cycle while out_ready is high.
// Depends on sfp_pkg.

module sfp_result_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sfp_pkg::step_out_t        push,
  output logic                      room2,
  output logic [sfp_pkg::FIFO_CW-1:0] fill,
  output logic                      out_valid,
  input  logic                      out_ready,
  output sfp_pkg::res_t             out_item
);

  sfp_pkg::res_t mem [sfp_pkg::FIFO_DEPTH];

  logic [sfp_pkg::FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [sfp_pkg::FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [sfp_pkg::FIFO_CW-1:0] count_r, count_nxt;
  logic [sfp_pkg::FIFO_AW-1:0] wr_ptr_p1;
  logic                        pop;

  assign pop       = out_valid && out_ready;
  assign wr_ptr_p1 = wr_ptr_r + sfp_pkg::FIFO_AW'(1);
  assign out_valid = (count_r != '0);
  assign out_item  = mem[rd_ptr_r];
  assign room2     = (count_r <= sfp_pkg::FIFO_CW'(sfp_pkg::FIFO_DEPTH - 2));
  assign fill      = count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + sfp_pkg::FIFO_AW'(push.n);
    rd_ptr_nxt = rd_ptr_r + sfp_pkg::FIFO_AW'(pop);
    count_nxt  = count_r + sfp_pkg::FIFO_CW'(push.n) - sfp_pkg::FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr_p1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: test/sync_length_crc16_frame_parser_top_test.sv
// Self-checking bench for sync_length_crc16_frame_parser_top: a directed table, then
// random UART blocks under several command-code settings, checked by an in-bench parser.
// Depends on sfp_pkg and the RTL of the frame parser.

module sync_length_crc16_frame_parser_top_test;

  localparam int RANDOM_ITEMS = 1950;      // random bytes over all code settings
  localparam int CODE_SETTINGS = 4;
  localparam int SETTLE_CYCLES = 8;        // settle margin after draining
  localparam int DRAIN_LIMIT = 4000;       // cycles to wait for outstanding results
  localparam int MAX_GAP = 13;
  localparam int MAX_PRINTS = 40;
  localparam logic [sfp_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;  // index the block drops

  // Parser phases of the bench's own parser
  localparam logic [2:0] WAIT_SYNC1  = 3'd0;
  localparam logic [2:0] WAIT_SYNC2  = 3'd1;
  localparam logic [2:0] WAIT_LEN    = 3'd2;
  localparam logic [2:0] WAIT_CMD    = 3'd3;
  localparam logic [2:0] IN_PAYLOAD  = 3'd4;
  localparam logic [2:0] WAIT_CRC_LO = 3'd5;
  localparam logic [2:0] WAIT_CRC_HI = 3'd6;
  localparam logic [2:0] SKIP_BLOCK  = 3'd7;

  // Where a directed byte comes from: literal, or the CRC of the frame so far
  typedef enum logic [1:0] {SRC_RAW, SRC_CRC_LO, SRC_CRC_HI, SRC_CRC_BAD} byte_src_t;

  typedef struct packed {
    logic [7:0]    val;
    byte_src_t     src;
    logic          blk_end;
    logic          typed;     // want holds the single expected item
    sfp_pkg::res_t want;
  } row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [7:0] in_rx_byte;
  logic in_block_end;
  logic out_valid;
  logic out_ready;
  logic out_kind;
  logic [7:0] out_data_byte;
  logic [6:0] out_byte_index;
  logic [2:0] out_status;
  logic [7:0] out_command;
  logic [7:0] out_payload_length;
  logic [15:0] out_frame_size;
  logic [1:0] out_reply;
  logic out_last;
  logic cfg_we;
  logic [sfp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [7:0] cfg_wdata;

  sync_length_crc16_frame_parser_top u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .in_block_end       (in_block_end),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_data_byte      (out_data_byte),
    .out_byte_index     (out_byte_index),
    .out_status         (out_status),
    .out_command        (out_command),
    .out_payload_length (out_payload_length),
    .out_frame_size     (out_frame_size),
    .out_reply          (out_reply),
    .out_last           (out_last),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  // Parser state mirrored by the bench
  logic [2:0]   phase;
  logic [15:0]  crc_acc;
  logic [7:0]   frm_len;
  logic [7:0]   frm_cmd;
  logic [7:0]   pay_cnt;
  logic [15:0]  size_acc;
  logic [7:0]   crc_lo_byte;
  logic [7:0]   ack_codes [3];

  // Items produced by the latest parsed byte
  sfp_pkg::res_t step_res [2];
  int   step_n;

  sfp_pkg::res_t parsed_items_q [$];   // items the block still owes, oldest first
  row_t dir_rows [$];
  int   errors;
  int   n_seen;
  int   rx_wait;
  logic rx_burst;
  logic tx_burst;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #1_500_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic flag_error(input string msg);
    if (errors < MAX_PRINTS) $display("ERROR item %0d: %s", n_seen, msg);
    errors++;
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want) flag_error($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // Bit-serial reflected CRC16, one byte
  function automatic logic [15:0] crc_step(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ b[k]) c = {1'b0, c[15:1]} ^ sfp_pkg::CRC_POLY;
      else c = {1'b0, c[15:1]};
    end
    return c;
  endfunction

  function automatic void add_summary(input logic [2:0] st, input logic [1:0] rp);
    sfp_pkg::res_t r;
    r = '0;
    r.kind = sfp_pkg::KIND_SUMMARY;
    r.status = st;
    r.command = frm_cmd;
    r.payload_length = frm_len;
    r.frame_size = size_acc;
    r.reply = rp;
    step_res[step_n] = r;
    step_n++;
  endfunction

  function automatic void add_payload(input logic [7:0] b, input logic [6:0] idx);
    sfp_pkg::res_t r;
    r = '0;
    r.kind = sfp_pkg::KIND_DATA;
    r.data_byte = b;
    r.byte_index = idx;
    step_res[step_n] = r;
    step_n++;
  endfunction

  function automatic sfp_pkg::res_t typed_summary(input logic [2:0] st, input logic [7:0] cmd,
                                                  input logic [7:0] len, input logic [1:0] rp);
    sfp_pkg::res_t r;
    r = '0;
    r.kind = sfp_pkg::KIND_SUMMARY;
    r.status = st;
    r.command = cmd;
    r.payload_length = len;
    r.reply = rp;
    r.last = 1'b1;
    return r;
  endfunction

  // Advance the mirrored parser by one byte; fills step_res/step_n
  function automatic void parse_byte(input logic [7:0] b, input logic e);
    logic done;
    logic [15:0] rx_crc;
    done = 1'b0;
    step_n = 0;
    case (phase)
      WAIT_SYNC1: begin
        // frame state restarts on every first sync byte looked at
        crc_acc = sfp_pkg::CRC_INIT;
        frm_len = '0;
        frm_cmd = '0;
        pay_cnt = '0;
        size_acc = '0;
        crc_lo_byte = '0;
        if (b != sfp_pkg::SYNC_FIRST) begin
          add_summary(sfp_pkg::ST_HEADER, sfp_pkg::RP_NONE);
          done = 1'b1;
        end else begin
          phase = WAIT_SYNC2;
        end
      end
      WAIT_SYNC2: begin
        if (b != sfp_pkg::SYNC_SECOND) begin
          add_summary(sfp_pkg::ST_HEADER, sfp_pkg::RP_NONE);
          done = 1'b1;
        end else begin
          phase = WAIT_LEN;
        end
      end
      WAIT_LEN: begin
        frm_len = b;
        crc_acc = crc_step(crc_acc, b);
        if (b > sfp_pkg::MAX_PAYLOAD) begin
          add_summary(sfp_pkg::ST_LONG, sfp_pkg::RP_NONE);
          done = 1'b1;
        end else begin
          phase = WAIT_CMD;
        end
      end
      WAIT_CMD: begin
        frm_cmd = b;
        crc_acc = crc_step(crc_acc, b);
        phase = (frm_len == 8'd0) ? WAIT_CRC_LO : IN_PAYLOAD;
      end
      IN_PAYLOAD: begin
        crc_acc = crc_step(crc_acc, b);
        add_payload(b, pay_cnt[6:0]);
        if (pay_cnt == 8'd0) size_acc = {8'h00, b};
        else if (pay_cnt == 8'd1) size_acc = {b, size_acc[7:0]};
        pay_cnt = pay_cnt + 8'd1;
        if (pay_cnt >= frm_len) phase = WAIT_CRC_LO;
      end
      WAIT_CRC_LO: begin
        crc_lo_byte = b;
        phase = WAIT_CRC_HI;
      end
      WAIT_CRC_HI: begin
        rx_crc = {b, crc_lo_byte};
        if (rx_crc != crc_acc) add_summary(sfp_pkg::ST_CRC, sfp_pkg::RP_NACK);
        else if (frm_cmd == ack_codes[0] || frm_cmd == ack_codes[1] ||
                 frm_cmd == ack_codes[2]) add_summary(sfp_pkg::ST_ACKED, sfp_pkg::RP_ACK);
        else add_summary(sfp_pkg::ST_PASSED, sfp_pkg::RP_NONE);
        done = 1'b1;
      end
      default: ;
    endcase
    if (e) begin
      // block ended before the frame closed
      if (!done && phase != SKIP_BLOCK) add_summary(sfp_pkg::ST_TRUNC, sfp_pkg::RP_NONE);
      phase = WAIT_SYNC1;
    end else if (done) begin
      phase = SKIP_BLOCK;
    end
    if (step_n > 0) step_res[step_n-1].last = 1'b1;
  endfunction

  // Predict, then offer one byte; returns at the falling edge after acceptance
  // with in_valid still high, so a back-to-back byte needs no second write.
  task automatic send_byte(input logic [7:0] b, input logic e, input logic typed,
                           input sfp_pkg::res_t want);
    int gap;
    parse_byte(b, e);
    if (typed) parsed_items_q.push_back(want);
    else for (int k = 0; k < step_n; k++) parsed_items_q.push_back(step_res[k]);
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    in_block_end <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic add_row(input logic [7:0] val, input byte_src_t src, input logic e,
                         input logic typed, input sfp_pkg::res_t want);
    row_t r;
    r.val = val;
    r.src = src;
    r.blk_end = e;
    r.typed = typed;
    r.want = want;
    dir_rows.push_back(r);
  endtask

  // Drop valid, let outstanding items come out, then let the pipe settle
  task automatic drain;
    in_valid <= 1'b0;
    for (int t = 0; t < DRAIN_LIMIT && parsed_items_q.size() != 0; t++) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Back-to-back writes of all three codes plus one to the dropped index
  task automatic write_codes(input logic [7:0] iv, input logic [7:0] sig,
                             input logic [7:0] size);
    cfg_we <= 1'b1;
    cfg_index <= sfp_pkg::CFG_IV;
    cfg_wdata <= iv;
    ack_codes[0] = iv;
    @(negedge clk);
    cfg_index <= sfp_pkg::CFG_SIG;
    cfg_wdata <= sig;
    ack_codes[1] = sig;
    @(negedge clk);
    cfg_index <= sfp_pkg::CFG_SIZE;
    cfg_wdata <= size;
    ack_codes[2] = size;
    @(negedge clk);
    cfg_index <= CFG_UNUSED;
    cfg_wdata <= 8'($urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // One random UART block; mostly well-formed frames, the rest faults and noise
  task automatic send_random_block(inout int sent);
    logic [7:0] blk [$];
    logic [15:0] crc;
    logic [7:0] cmd;
    logic [7:0] b;
    int sel;
    int len;
    int cut;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      sel = $urandom_range(0, 99);
      if (sel < 3) len = $urandom_range(0, 1) ? sfp_pkg::MAX_PAYLOAD :
                         $urandom_range(100, sfp_pkg::MAX_PAYLOAD - 1);
      else if (sel < 12) len = $urandom_range(9, 40);
      else len = $urandom_range(0, 8);
      cmd = ($urandom_range(0, 9) < 6) ? ack_codes[$urandom_range(0, 2)] : 8'($urandom);
      blk.push_back(sfp_pkg::SYNC_FIRST);
      blk.push_back(sfp_pkg::SYNC_SECOND);
      blk.push_back(8'(len));
      blk.push_back(cmd);
      crc = crc_step(crc_step(sfp_pkg::CRC_INIT, 8'(len)), cmd);
      repeat (len) begin
        b = 8'($urandom);
        blk.push_back(b);
        crc = crc_step(crc, b);
      end
      if ($urandom_range(0, 9) == 0) crc = crc ^ (16'd1 << $urandom_range(0, 15));
      blk.push_back(crc[7:0]);
      blk.push_back(crc[15:8]);
      repeat ($urandom_range(0, 2)) blk.push_back(8'($urandom));
      // cut the block short somewhere now and then
      if ($urandom_range(0, 9) == 0) begin
        cut = $urandom_range(1, blk.size() - 1);
        while (blk.size() > cut) void'(blk.pop_back());
      end
    end else if (sel < 80) begin
      // wrong first sync, or right first and wrong second
      if ($urandom_range(0, 1)) begin
        blk.push_back(sfp_pkg::SYNC_FIRST);
        b = 8'($urandom);
        if (b == sfp_pkg::SYNC_SECOND) b = ~b;
      end else begin
        b = 8'($urandom);
        if (b == sfp_pkg::SYNC_FIRST) b = ~b;
      end
      blk.push_back(b);
      repeat ($urandom_range(0, 3)) blk.push_back(8'($urandom));
    end else if (sel < 88) begin
      blk.push_back(sfp_pkg::SYNC_FIRST);
      blk.push_back(sfp_pkg::SYNC_SECOND);
      len = $urandom_range(0, 1) ? sfp_pkg::MAX_PAYLOAD + 1 :
            $urandom_range(sfp_pkg::MAX_PAYLOAD + 2, 255);
      blk.push_back(8'(len));
      repeat ($urandom_range(0, 2)) blk.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 6)) blk.push_back(8'($urandom));
    end
    foreach (blk[i]) send_byte(blk[i], i == blk.size() - 1, 1'b0, '0);
    sent += blk.size();
  endtask

  // Receiver: out_ready drops for a drawn number of cycles after each item
  always @(negedge clk) begin
    if (rx_wait > 0) begin
      out_ready <= 1'b0;
      rx_wait--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result check against the oldest outstanding item
  always @(posedge clk) begin : result_check
    sfp_pkg::res_t got;
    sfp_pkg::res_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_kind, out_data_byte, out_byte_index, out_status, out_command,
             out_payload_length, out_frame_size, out_reply, out_last};
      if (parsed_items_q.size() == 0) begin
        flag_error("result item with nothing outstanding");
      end else begin
        want = parsed_items_q.pop_front();
        compare_field("kind", 16'(got.kind), 16'(want.kind));
        compare_field("data_byte", 16'(got.data_byte), 16'(want.data_byte));
        compare_field("byte_index", 16'(got.byte_index), 16'(want.byte_index));
        compare_field("status", 16'(got.status), 16'(want.status));
        compare_field("command", 16'(got.command), 16'(want.command));
        compare_field("payload_length", 16'(got.payload_length), 16'(want.payload_length));
        compare_field("frame_size", got.frame_size, want.frame_size);
        compare_field("reply", 16'(got.reply), 16'(want.reply));
        compare_field("last", 16'(got.last), 16'(want.last));
      end
      n_seen++;
      // mostly random stalls, with no-stall stretches now and then
      if ($urandom_range(0, 63) == 0) rx_burst = ~rx_burst;
      rx_wait = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
    end
  end

  initial begin : stimulus
    int sent;
    logic [7:0] b;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = '0;
    in_block_end = 1'b0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    errors = 0;
    n_seen = 0;
    rx_wait = 0;
    rx_burst = 1'b0;
    tx_burst = 1'b0;
    // mirror of the reset state
    phase = WAIT_SYNC1;
    crc_acc = sfp_pkg::CRC_INIT;
    frm_len = '0;
    frm_cmd = '0;
    pay_cnt = '0;
    size_acc = '0;
    crc_lo_byte = '0;
    ack_codes[0] = 8'd1;
    ack_codes[1] = 8'd2;
    ack_codes[2] = 8'd3;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table, reset code values. Typed rows carry their own expectation.
    // bad first sync right after reset, then the rest of the block is skipped
    add_row(8'h00, SRC_RAW, 1'b0, 1'b1,
            typed_summary(sfp_pkg::ST_HEADER, 8'h00, 8'h00, sfp_pkg::RP_NONE));
    add_row(8'hFF, SRC_RAW, 1'b1, 1'b0, '0);
    // bad second sync on the last byte: header error only, no truncation
    add_row(sfp_pkg::SYNC_FIRST, SRC_RAW, 1'b0, 1'b0, '0);
    add_row(8'h00, SRC_RAW, 1'b1, 1'b1,
            typed_summary(sfp_pkg::ST_HEADER, 8'h00, 8'h00, sfp_pkg::RP_NONE));
    // longest length byte, on the last byte: too long only
    add_row(sfp_pkg::SYNC_FIRST, SRC_RAW, 1'b0, 1'b0, '0);
    add_row(sfp_pkg::SYNC_SECOND, SRC_RAW, 1'b0, 1'b0, '0);
    add_row(8'hFF, SRC_RAW, 1'b1, 1'b1,
            typed_summary(sfp_pkg::ST_LONG, 8'h00, 8'hFF, sfp_pkg::RP_NONE));
    // empty payload, acked command, then a trailing byte that is ignored
    add_row(sfp_pkg::SYNC_FIRST, SRC_RAW, 1'b0, 1'b0, '0);
    add_row(sfp_pkg::SYNC_SECOND, SRC_RAW, 1'b0, 1'b0, '0);
    add_row(8'h00, SRC_RAW, 1'b0, 1'b0, '0);
    add_row(8'h01, SRC_RAW, 1'b0, 1'b0, '0);
    add_row(8'h00, SRC_CRC_LO, 1'b0, 1'b0, '0);
    add_row(8'h00, SRC_CRC_HI, 1'b0, 1'b1,
            typed_summary(sfp_pkg::ST_ACKED, 8'h01, 8'h00, sfp_pkg::RP_ACK));
    add_row(8'h5A, SRC_RAW, 1'b1, 1'b0, '0);
    // one-byte payload, unlisted command, corrupted CRC high byte
    add_row(sfp_pkg::SYNC_FIRST, SRC_RAW, 1'b0, 1'b0, '0);
    add_row(sfp_pkg::SYNC_SECOND, SRC_RAW, 1'b0, 1'b0, '0);
    add_row(8'h01, SRC_RAW, 1'b0, 1'b0, '0);
    add_row(8'hFF, SRC_RAW, 1'b0, 1'b0, '0);
    add_row(8'h00, SRC_RAW, 1'b0, 1'b0, '0);
    add_row(8'h00, SRC_CRC_LO, 1'b0, 1'b0, '0);
    add_row(8'h00, SRC_CRC_BAD, 1'b1, 1'b0, '0);
    // block ends on a payload byte: payload item, then truncation
    add_row(sfp_pkg::SYNC_FIRST, SRC_RAW, 1'b0, 1'b0, '0);
    add_row(sfp_pkg::SYNC_SECOND, SRC_RAW, 1'b0, 1'b0, '0);
    add_row(8'h02, SRC_RAW, 1'b0, 1'b0, '0);
    add_row(8'h03, SRC_RAW, 1'b0, 1'b0, '0);
    add_row(8'h34, SRC_RAW, 1'b1, 1'b0, '0);

    foreach (dir_rows[i]) begin
      case (dir_rows[i].src)
        SRC_CRC_LO:  b = crc_acc[7:0];
        SRC_CRC_HI:  b = crc_acc[15:8];
        SRC_CRC_BAD: b = ~crc_acc[15:8];
        default:     b = dir_rows[i].val;
      endcase
      send_byte(b, dir_rows[i].blk_end, dir_rows[i].typed, dir_rows[i].want);
    end
    drain();

    // Random blocks under each code setting: reset values, both extremes, random
    for (int s = 0; s < CODE_SETTINGS; s++) begin
      case (s)
        1: write_codes(8'h00, 8'hFF, sfp_pkg::MAX_PAYLOAD);
        2: write_codes(8'hFF, 8'h00, sfp_pkg::SYNC_FIRST);
        3: write_codes(8'($urandom), 8'($urandom), 8'($urandom));
        default: ;
      endcase
      sent = 0;
      while (sent < RANDOM_ITEMS / CODE_SETTINGS) begin
        tx_burst = ($urandom_range(0, 7) == 0);
        send_random_block(sent);
      end
      drain();
    end

    if (parsed_items_q.size() != 0)
      flag_error($sformatf("%0d expected items never came", parsed_items_q.size()));
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/sfp_pkg.sv
rtl/sfp_parser_step.sv
rtl/sfp_result_fifo.sv
rtl/sync_length_crc16_frame_parser_top.sv
test/sync_length_crc16_frame_parser_top_test.sv
